// ===== rtl/stmm_pkg.sv =====
// Shared types and constants for the sparse-table range min/max engine.
// Holds the sequencer state type, request codes and stream word layout.
// No dependencies.
package stmm_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_BUILD,
    ST_DRAIN
  } stmm_state_t;

  // request kinds carried on s_tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // input word layout
  localparam int LOAD_VALUE_LSB = 0;
  localparam int LOAD_VALUE_W   = 32;
  localparam int RANGE_FROM_LSB = 32;
  localparam int RANGE_TO_LSB   = 42;
  localparam int RANGE_W        = 10;
  localparam int S_TDATA_W      = 56;

  // output word layout
  localparam int M_TDATA_W      = 32;

endpackage

// ===== rtl/sparse_table_range_min_max.sv =====
// Sparse-table range minimum/maximum engine, top level.
// A query reads both blocks into the read registers; the result register then takes their
// combination once the output is free. Loads are written to level 0 as they are taken. No new
// request is taken until a query's result is loaded. Build after the last load: one entry per
// cycle through the table's dual read port, input stalled meanwhile.
// Reset (rst, synchronous): clears count, fill index, mode and handshake state; table undefined.
module sparse_table_range_min_max #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration: max_mode
  input  logic                             cfg_we,
  input  logic                             cfg_wdata,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [stmm_pkg::S_TDATA_W-1:0]   s_tdata,  // load_value[31:0], range_from[41:32],
                                                     // range_to[51:42], zero pad[55:52]
  input  logic                             s_tuser,  // req_type
  input  logic                             s_tlast,  // load_last
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [stmm_pkg::M_TDATA_W-1:0]   m_tdata,  // range_result[31:0]
  output logic                             m_tuser   // range_error
);

  // Table geometry: level k holds combinations over 2^k elements, levels 0..floor(log2(MAX)).
  localparam int LEVELS = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int DEPTH  = LEVELS * (1 << IDX_W);
  // query index arithmetic width: wide enough for the 10-bit port and the table index
  localparam int Q_W    = (IDX_W > stmm_pkg::RANGE_W) ? IDX_W : stmm_pkg::RANGE_W;
  localparam int Q1_W   = Q_W + 1;
  localparam int LEN_W  = stmm_pkg::RANGE_W + 1;
  localparam int LG_W   = (LVL_W > 4) ? LVL_W : 4;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  // Pick the smaller (or larger, in max mode) of two signed values.
  function automatic logic signed [VALUE_BITS-1:0] pick(
    input logic signed [VALUE_BITS-1:0] a,
    input logic signed [VALUE_BITS-1:0] b,
    input logic                         use_max
  );
    logic a_less;
    a_less = (a < b);
    if (use_max) begin
      return a_less ? b : a;
    end
    return a_less ? a : b;
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  stmm_pkg::stmm_state_t state, state_next;

  logic                         max_mode;
  logic [CNT_W-1:0]             element_count;
  logic [CNT_W-1:0]             fill_index;
  logic [LVL_W-1:0]             lvl;          // level being built
  logic [IDX_W-1:0]             idx;          // entry being read for the build
  logic [IDX_W-1:0]             last_idx;     // last start index of this level
  logic [IDX_W-1:0]             half;         // 2^(lvl-1)
  logic [CNT_W-1:0]             span;         // 2^lvl
  logic                         wr_pend;      // build write due this cycle
  logic [ADDR_W-1:0]            wr_addr;
  logic                         err_q;        // query error, held with the read

  // table memory: one write port, two registered read ports
  logic signed [VALUE_BITS-1:0] table_mem [DEPTH];
  logic signed [VALUE_BITS-1:0] rd_a;
  logic signed [VALUE_BITS-1:0] rd_b;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic                         s_accept;
  logic                         is_query;
  logic signed [stmm_pkg::LOAD_VALUE_W-1:0] load_value;
  logic [stmm_pkg::RANGE_W-1:0] range_from;
  logic [stmm_pkg::RANGE_W-1:0] range_to;
  logic [CNT_W-1:0]             fill_next;
  logic                         fill_room;
  logic                         q_error;
  logic [LEN_W-1:0]             q_len;
  logic [LG_W-1:0]              q_lg;
  logic [Q_W-1:0]               q_from;
  logic [Q1_W-1:0]              q_b;
  logic [CNT_W:0]               span_dbl;
  logic                         out_free;
  logic                         out_load;

  assign s_accept   = s_tvalid && s_tready;
  assign is_query   = (s_tuser == stmm_pkg::REQ_QUERY);
  assign load_value = s_tdata[stmm_pkg::LOAD_VALUE_LSB +: stmm_pkg::LOAD_VALUE_W];
  assign range_from = s_tdata[stmm_pkg::RANGE_FROM_LSB +: stmm_pkg::RANGE_W];
  assign range_to   = s_tdata[stmm_pkg::RANGE_TO_LSB +: stmm_pkg::RANGE_W];

  // drop loads past the table size
  assign fill_room  = (fill_index < MAX_CNT);
  assign fill_next  = fill_room ? fill_index + CNT_W'(1) : fill_index;

  // empty range, or a range reaching past the loaded values
  assign q_error = (range_from > range_to) || (range_to >= element_count);
  assign q_len   = LEN_W'(range_to) - LEN_W'(range_from) + LEN_W'(1);

  // floor(log2(length)): highest set bit
  always_comb begin
    q_lg = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (q_len[i]) begin
        q_lg = LG_W'(i);
      end
    end
  end

  // two overlapping blocks: one starts at from, the other ends at to
  assign q_from = Q_W'(range_from);
  assign q_b    = Q1_W'(range_to) + Q1_W'(1) - (Q1_W'(1) << q_lg);

  assign span_dbl = {span, 1'b0};
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == stmm_pkg::ST_QUERY) && out_free;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      stmm_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (is_query) begin
            state_next = stmm_pkg::ST_QUERY;
          end else if (s_tlast && (fill_next >= CNT_W'(2))) begin
            state_next = stmm_pkg::ST_BUILD;
          end
        end
      end
      stmm_pkg::ST_QUERY: begin
        if (out_free) begin
          state_next = stmm_pkg::ST_IDLE;
        end
      end
      stmm_pkg::ST_BUILD: begin
        if (idx == last_idx) begin
          state_next = stmm_pkg::ST_DRAIN;
        end
      end
      stmm_pkg::ST_DRAIN: begin
        if (span_dbl <= (CNT_W + 1)'(element_count)) begin
          state_next = stmm_pkg::ST_BUILD;
        end else begin
          state_next = stmm_pkg::ST_IDLE;
        end
      end
      default: state_next = stmm_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (memory port control)
  // ---------------------------------------------------------------------------
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic signed [VALUE_BITS-1:0] mem_wdata;
  logic                         rd_en;
  logic [ADDR_W-1:0]            rd_addr_a;
  logic [ADDR_W-1:0]            rd_addr_b;
  logic [LVL_W-1:0]             src_lvl;

  assign src_lvl = lvl - LVL_W'(1);

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = pick(rd_a, rd_b, max_mode);
    rd_en     = 1'b0;
    rd_addr_a = {q_lg[LVL_W-1:0], q_from[IDX_W-1:0]};
    rd_addr_b = {q_lg[LVL_W-1:0], q_b[IDX_W-1:0]};
    case (state)
      stmm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_accept && is_query) begin
          rd_en = 1'b1;
        end
        // append the value to level 0
        if (s_accept && !is_query && fill_room) begin
          mem_we    = 1'b1;
          mem_waddr = {LVL_W'(0), fill_index[IDX_W-1:0]};
          mem_wdata = VALUE_BITS'(load_value);
        end
      end
      stmm_pkg::ST_BUILD: begin
        rd_en     = 1'b1;
        rd_addr_a = {src_lvl, idx};
        rd_addr_b = {src_lvl, idx + half};
        mem_we    = wr_pend;
      end
      stmm_pkg::ST_DRAIN: begin
        mem_we = wr_pend;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_a <= table_mem[rd_addr_a];
      rd_b <= table_mem[rd_addr_b];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= stmm_pkg::ST_IDLE;
      max_mode      <= 1'b0;
      element_count <= '0;
      fill_index    <= '0;
      lvl           <= '0;
      idx           <= '0;
      last_idx      <= '0;
      half          <= '0;
      span          <= '0;
      wr_pend       <= 1'b0;
      err_q         <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        max_mode <= cfg_wdata;
      end

      // each build read turns into a write in the next cycle
      wr_pend <= (state == stmm_pkg::ST_BUILD);

      case (state)
        stmm_pkg::ST_IDLE: begin
          if (s_accept && is_query) begin
            err_q <= q_error;
          end
          if (s_accept && !is_query) begin
            if (s_tlast) begin
              // close the load and set up level 1
              element_count <= fill_next;
              fill_index    <= '0;
              lvl           <= LVL_W'(1);
              idx           <= '0;
              half          <= IDX_W'(1);
              span          <= CNT_W'(2);
              last_idx      <= IDX_W'(fill_next - CNT_W'(2));
            end else begin
              element_count <= '0;
              fill_index    <= fill_next;
            end
          end
        end
        stmm_pkg::ST_BUILD: begin
          if (idx != last_idx) begin
            idx <= idx + IDX_W'(1);
          end
        end
        stmm_pkg::ST_DRAIN: begin
          // advance to the next level
          lvl      <= lvl + LVL_W'(1);
          idx      <= '0;
          half     <= IDX_W'(span);
          span     <= CNT_W'(span_dbl);
          last_idx <= IDX_W'((CNT_W + 1)'(element_count) - span_dbl);
        end
        default: begin
          idx <= idx;
        end
      endcase

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // pending build write targets the entry read last cycle
  always_ff @(posedge clk) begin
    wr_addr <= {lvl, idx};
  end

  // ---------------------------------------------------------------------------
  // Result register: combine the two blocks with the current mode
  // ---------------------------------------------------------------------------
  logic signed [VALUE_BITS-1:0] q_pick;

  assign q_pick = pick(rd_a, rd_b, max_mode);

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= err_q ? '0 : stmm_pkg::M_TDATA_W'(q_pick);
      m_tuser <= err_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wr_after_read: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> $past(state) == stmm_pkg::ST_BUILD)
    else $error("build write without a preceding read");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == stmm_pkg::ST_BUILD |-> idx <= last_idx)
    else $error("build index past level end");

  a_span_fits: assert property (@(posedge clk) disable iff (rst)
    state == stmm_pkg::ST_BUILD |-> span <= element_count)
    else $error("level span exceeds loaded count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= MAX_CNT && fill_index <= MAX_CNT)
    else $error("count beyond table size");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("error result carries data");

endmodule
